/* rtl/usd_pkg.sv */
// ----------------------------------------------------------------------------
// usd_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package usd_pkg;

   localparam int CP_WIDTH            = 21;
   localparam int BYTE_WIDTH          = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // code point limits used by the final checks
   localparam logic [CP_WIDTH-1:0] CP_MAX      = 21'h10FFFF;
   localparam logic [CP_WIDTH-1:0] SURR_LO     = 21'h00D800;
   localparam logic [CP_WIDTH-1:0] SURR_HI     = 21'h00DFFF;
   localparam logic [CP_WIDTH-1:0] MAX_ONE_B   = 21'h00007F;
   localparam logic [CP_WIDTH-1:0] MAX_TWO_B   = 21'h0007FF;
   localparam logic [CP_WIDTH-1:0] MAX_THREE_B = 21'h00FFFF;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_EOF          = 3'd1,
      ST_STRAY_CONT   = 3'd2,
      ST_BAD_LEAD     = 3'd3,
      ST_MISSING_CONT = 3'd4,
      ST_BAD_CONT     = 3'd5,
      ST_RANGE        = 3'd6,
      ST_OVERLONG     = 3'd7
   } status_type;

   // byte classes by count of leading ones
   typedef enum logic [2:0] {
      BC_ASCII,
      BC_CONT,
      BC_LEAD2,
      BC_LEAD3,
      BC_LEAD4,
      BC_BAD
   } byte_class_type;

   // one result transaction
   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      status_type          status;
      logic                run_end;
   } rsp_item_type;

   // decoder sequence state
   typedef struct packed {
      logic [CP_WIDTH-1:0] partial;
      logic [1:0]          remaining;
      logic [1:0]          seq_len;
      logic                bad_cont;
   } dec_state_type;

   // everything one byte produces
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type slot0;
      rsp_item_type slot1;
   } dec_out_type;

endpackage

/* rtl/usd_decoder.sv */
// ----------------------------------------------------------------------------
// usd_decoder
// Sequence state and single-pass byte decode, up to two results per byte.
// ----------------------------------------------------------------------------
module usd_decoder
   import usd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  logic                  advance,
   input  logic [BYTE_WIDTH-1:0] byte_value,
   input  logic                  end_of_input,
   output dec_out_type           dec_out
);

   typedef struct packed {
      logic          has_result;
      rsp_item_type  result;
      dec_state_type state;
   } idle_out_type;

   dec_state_type state_ff;
   dec_state_type state_in;

   // classify a byte by its leading ones
   function automatic byte_class_type classify(input logic [BYTE_WIDTH-1:0] b);
      byte_class_type cls;
      unique casez (b)
         8'b0???????: cls = BC_ASCII;
         8'b10??????: cls = BC_CONT;
         8'b110?????: cls = BC_LEAD2;
         8'b1110????: cls = BC_LEAD3;
         8'b11110???: cls = BC_LEAD4;
         default:     cls = BC_BAD;
      endcase
      return cls;
   endfunction

   // handling of a byte with no sequence open
   function automatic idle_out_type idle_byte(input logic [BYTE_WIDTH-1:0] b,
                                              input logic eoi);
      idle_out_type        o;
      logic [1:0]          len;
      logic [CP_WIDTH-1:0] payload;
      o          = '0;
      len        = 2'd0;
      payload    = '0;
      o.result.status = ST_OK;
      unique case (classify(b))
         BC_ASCII: begin
            o.has_result        = 1'b1;
            o.result.code_point = CP_WIDTH'(b);
         end
         BC_CONT: begin
            o.has_result    = 1'b1;
            o.result.status = ST_STRAY_CONT;
         end
         BC_LEAD2: begin
            len     = 2'd1;
            payload = CP_WIDTH'(b[4:0]);
         end
         BC_LEAD3: begin
            len     = 2'd2;
            payload = CP_WIDTH'(b[3:0]);
         end
         BC_LEAD4: begin
            len     = 2'd3;
            payload = CP_WIDTH'(b[2:0]);
         end
         default: begin
            o.has_result    = 1'b1;
            o.result.status = ST_BAD_LEAD;
         end
      endcase
      // a lead byte opens a sequence unless input ends here
      if (len != 2'd0) begin
         if (eoi) begin
            o.has_result    = 1'b1;
            o.result.status = ST_EOF;
         end else begin
            o.state.partial   = payload;
            o.state.remaining = len;
            o.state.seq_len   = len;
         end
      end
      return o;
   endfunction

   byte_class_type      cls;
   idle_out_type        idle_res;
   logic [CP_WIDTH-1:0] partial_new;
   logic [1:0]          rem_new;
   logic                bad_new;
   logic                out_of_range;
   logic [1:0]          need_cont;

   // decode of the registered byte against the current state
   always_comb begin
      cls         = classify(byte_value);
      idle_res    = idle_byte(byte_value, end_of_input);
      partial_new = (cls == BC_CONT) ? {state_ff.partial[CP_WIDTH-7:0], byte_value[5:0]}
                                     : state_ff.partial;
      rem_new     = state_ff.remaining - 2'd1;
      bad_new     = state_ff.bad_cont | (cls == BC_BAD);
      out_of_range = (partial_new > CP_MAX) ||
                     ((partial_new >= SURR_LO) && (partial_new <= SURR_HI));
      if (partial_new <= MAX_ONE_B) begin
         need_cont = 2'd0;
      end else if (partial_new <= MAX_TWO_B) begin
         need_cont = 2'd1;
      end else if (partial_new <= MAX_THREE_B) begin
         need_cont = 2'd2;
      end else begin
         need_cont = 2'd3;
      end

      dec_out  = '0;
      dec_out.slot0.status = ST_OK;
      dec_out.slot1.status = ST_OK;
      state_in = '0;

      if (state_ff.remaining == 2'd0) begin
         dec_out.count = {1'b0, idle_res.has_result};
         dec_out.slot0 = idle_res.result;
         state_in      = idle_res.state;
      end else if (cls == BC_CONT || cls == BC_BAD) begin
         // continuation slot consumed
         if (rem_new == 2'd0) begin
            dec_out.count = 2'd1;
            if (bad_new) begin
               dec_out.slot0.status = ST_BAD_CONT;
            end else if (out_of_range) begin
               dec_out.slot0.code_point = partial_new;
               dec_out.slot0.status     = ST_RANGE;
            end else if (need_cont < state_ff.seq_len) begin
               dec_out.slot0.code_point = partial_new;
               dec_out.slot0.status     = ST_OVERLONG;
            end else begin
               dec_out.slot0.code_point = partial_new;
            end
         end else if (end_of_input) begin
            dec_out.count        = 2'd1;
            dec_out.slot0.status = ST_EOF;
         end else begin
            state_in.partial   = partial_new;
            state_in.remaining = rem_new;
            state_in.seq_len   = state_ff.seq_len;
            state_in.bad_cont  = bad_new;
         end
      end else begin
         // missing continuation, then the byte again as a fresh one
         dec_out.slot0.status = ST_MISSING_CONT;
         dec_out.slot1        = idle_res.result;
         dec_out.count        = idle_res.has_result ? 2'd2 : 2'd1;
         state_in             = idle_res.state;
      end

      // the last result of the byte closes its run
      dec_out.slot0.run_end = (dec_out.count == 2'd1);
      dec_out.slot1.run_end = 1'b1;
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   a_two_needs_missing: assert property (@(posedge clock) disable iff (reset)
      (byte_valid && dec_out.count == 2'd2) |-> dec_out.slot0.status == ST_MISSING_CONT)
      else $error("second result without a missing continuation");

   a_rem_within_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff.remaining != 2'd0) |-> (state_ff.remaining <= state_ff.seq_len))
      else $error("remaining count exceeds sequence length");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff.remaining == 2'd0) |-> !state_ff.bad_cont)
      else $error("bad continuation flag left set while idle");

endmodule

/* rtl/usd_result_queue.sv */
// ----------------------------------------------------------------------------
// usd_result_queue
// Small result queue taking up to two entries per cycle, draining one while rsp_ready is high.
// ----------------------------------------------------------------------------
module usd_result_queue
   import usd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   push_count,
   input  rsp_item_type push0,
   input  rsp_item_type push1,
   output logic         room_two,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rsp_item_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic             pop;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // status and head
   assign rsp_valid   = (count_ff != '0);
   assign rsp_item    = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;
   assign room_two    = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
   assign wr_ptr_next = wrap_inc(wr_ptr_ff);

   // pointer and count update
   always_comb begin
      unique case (push_count)
         2'd1:    wr_ptr_in = wr_ptr_next;
         2'd2:    wr_ptr_in = wrap_inc(wr_ptr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (push_count != 2'd0 && wr_ptr_ff == PTR_W'(i)) begin
            entry_ff[i] <= push0;
         end else if (push_count == 2'd2 && wr_ptr_next == PTR_W'(i)) begin
            entry_ff[i] <= push1;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("result queue count beyond depth");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      (push_count != 2'd0) |-> room_two)
      else $error("push into result queue without room");

endmodule

/* rtl/utf8_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// UTF-8 byte stream to code point decoder with error status per result.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while the input register is empty or the
// result queue has room for two results. A byte sits in the input register,
// is decoded in a single pass against the sequence state and drops zero, one
// or two results into a small result queue, so the first result of a byte
// passes the input register and then the queue before it is offered. The
// result port drains one result per cycle while rsp_ready is high; a byte that
// reports a missing continuation and then yields its own result fills two
// queue slots, and the queue depth (QUEUE_DEPTH) sets how far the input can run ahead of a stalled result side.
module utf8_stream_decoder_unit
   import usd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_WIDTH-1:0] req_byte_value,
   input  logic                  req_end_of_input,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CP_WIDTH-1:0]   rsp_code_point,
   output logic [2:0]            rsp_status,
   output logic                  rsp_run_end
);

   logic                  in_valid_ff, in_valid_in;
   logic [BYTE_WIDTH-1:0] in_byte_ff;
   logic                  in_eoi_ff;
   logic                  room_two;
   logic                  advance;
   logic                  req_fire;
   dec_out_type           dec_out;
   rsp_item_type          rsp_item;
   logic [1:0]            push_count;

   // input register handshake
   assign advance     = in_valid_ff && room_two;
   assign req_ready   = !in_valid_ff || room_two;
   assign req_fire    = req_valid && req_ready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);
   assign push_count  = advance ? dec_out.count : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_byte_value;
         in_eoi_ff  <= req_end_of_input;
      end
   end

   // byte decode
   usd_decoder u_decoder (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (in_valid_ff),
      .advance      (advance),
      .byte_value   (in_byte_ff),
      .end_of_input (in_eoi_ff),
      .dec_out      (dec_out)
   );

   // result queue
   usd_result_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_result_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (dec_out.slot0),
      .push1      (dec_out.slot1),
      .room_two   (room_two),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

   // result ports
   assign rsp_code_point = rsp_item.code_point;
   assign rsp_status     = rsp_item.status;
   assign rsp_run_end    = rsp_item.run_end;

endmodule
